// File: design/ita_pkg.sv
// Shared types, codes and character helpers for the integer-to-ASCII formatter.
`default_nettype none

package ita_pkg;

    typedef enum logic [1:0] {
        MODE_UDEC = 2'd0,
        MODE_SDEC = 2'd1,
        MODE_LHEX = 2'd2,
        MODE_UHEX = 2'd3
    } t_mode;

    localparam int WIDTH_W    = 6;
    localparam int DIGITS_MAX = 10;
    localparam int NDIG_W     = $clog2(DIGITS_MAX + 1);
    localparam int DIGIT_IDX_W = $clog2(DIGITS_MAX);

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    // 2^35 / 10 rounded up; exact quotient for every 32-bit dividend
    localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
    localparam int          RECIP_SH = 35;

    typedef struct packed {
        logic [31:0]        mag;
        logic               neg;
        logic               hex;
        logic               upper;
        logic               zero_fill;
        logic [WIDTH_W-1:0] width;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_STORE,
        BK_SIGN,
        BK_PAD,
        BK_DIGIT
    } t_back_state;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        if (d < 4'd10) begin
            digit_char = CH_ZERO + {4'd0, d};
        end else begin
            base = upper ? CH_UPPER_A : CH_LOWER_A;
            digit_char = base + {4'd0, d} - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

// File: design/ita_if.sv
// Valid/ready channel interfaces for the number beat and the character beat.
`default_nettype none

interface ita_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] value;
    logic [5:0]  min_width;
    logic        zero_fill;

    modport source (output valid, mode, value, min_width, zero_fill, input ready);
    modport sink   (input valid, mode, value, min_width, zero_fill, output ready);
endinterface

interface ita_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last;

    modport source (output valid, char_out, last, input ready);
    modport sink   (input valid, char_out, last, output ready);
endinterface

`default_nettype wire

// File: design/ita_front.sv
// Front end: accepts a number beat, clamps the width and splits sign from magnitude.
`default_nettype none

module ita_front import ita_pkg::*; #(
    parameter int MAX_WIDTH = 32
) (
    ita_in_if.sink      i_item,
    input  wire logic   i_q_ready,
    output t_job        o_job,
    output logic        o_push
);

    logic               w_neg;
    logic [WIDTH_W-1:0] w_clamped;

    assign i_item.ready = i_q_ready;
    assign o_push       = i_item.valid && i_q_ready;

    always_comb begin
        w_neg = (t_mode'(i_item.mode) == MODE_SDEC) && i_item.value[31];
        if ({1'b0, i_item.min_width} > 7'(MAX_WIDTH)) begin
            w_clamped = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_clamped = i_item.min_width;
        end

        o_job.mag       = w_neg ? (~i_item.value + 32'd1) : i_item.value;
        o_job.neg       = w_neg;
        o_job.hex       = i_item.mode[1];
        o_job.upper     = (t_mode'(i_item.mode) == MODE_UHEX);
        o_job.zero_fill = i_item.zero_fill;
        o_job.width     = (w_neg && w_clamped != '0) ? (w_clamped - 6'd1) : w_clamped;
    end

endmodule

`default_nettype wire

// File: design/ita_queue.sv
// Two-entry job queue between the front end and the back end.
`default_nettype none

module ita_queue import ita_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_ready,
    output t_job      o_job,
    output logic      o_valid,
    input  wire logic i_pop
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_count == 2'd2))
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == 2'd0))
        else $error("job popped from empty queue");

endmodule

`default_nettype wire

// File: design/ita_back.sv
// Back end: extracts digits by divide and store steps, then emits sign, padding and digits.
`default_nettype none

module ita_back import ita_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_job       i_job,
    input  wire logic  i_job_valid,
    output logic       o_job_pop,
    ita_out_if.source  o_out
);

    t_back_state        r_state;
    t_back_state        n_state;

    logic [31:0]        r_val;
    logic [31:0]        r_quot;
    logic               r_neg;
    logic               r_hex;
    logic               r_upper;
    logic               r_zero_fill;
    logic [WIDTH_W-1:0] r_width;
    logic [WIDTH_W-1:0] r_pad;
    logic [NDIG_W-1:0]  r_ndig;
    logic [3:0]         r_digits [DIGITS_MAX];

    logic               r_out_valid;
    logic [7:0]         r_out_char;
    logic               r_out_last;

    logic               w_slot_free;
    logic               w_emit;
    logic [7:0]         w_emit_char;
    logic               w_emit_last;
    logic [63:0]        w_prod;
    logic [3:0]         w_digit;
    logic [3:0]         w_top_digit;

    assign w_slot_free   = !r_out_valid || o_out.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.char_out = r_out_char;
    assign o_out.last    = r_out_last;

    assign w_prod  = 64'(r_val) * 64'(RECIP_10);
    assign w_digit = r_hex ? r_val[3:0] : (r_val[3:0] - 4'(r_quot[3:0] * 4'd10));
    assign w_top_digit = r_digits[DIGIT_IDX_W'(r_ndig - NDIG_W'(1))];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                n_state = BK_STORE;
            end
            BK_STORE: begin
                n_state = (r_quot == '0) ? BK_SIGN : BK_DIV;
            end
            BK_SIGN: begin
                if (!r_neg || w_slot_free) begin
                    n_state = BK_PAD;
                end
            end
            BK_PAD: begin
                if (r_pad == '0) begin
                    n_state = BK_DIGIT;
                end
            end
            BK_DIGIT: begin
                if (w_slot_free && r_ndig == NDIG_W'(1)) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop   = 1'b0;
        w_emit      = 1'b0;
        w_emit_char = CH_ZERO;
        w_emit_last = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                o_job_pop = i_job_valid;
            end
            BK_SIGN: begin
                w_emit      = r_neg && w_slot_free;
                w_emit_char = CH_MINUS;
            end
            BK_PAD: begin
                w_emit      = (r_pad != '0) && w_slot_free;
                w_emit_char = r_zero_fill ? CH_ZERO : CH_SPACE;
            end
            BK_DIGIT: begin
                w_emit      = w_slot_free;
                w_emit_char = digit_char(w_top_digit, r_upper);
                w_emit_last = (r_ndig == NDIG_W'(1));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_char <= w_emit_char;
            r_out_last <= w_emit_last;
        end
        unique case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    r_val       <= i_job.mag;
                    r_neg       <= i_job.neg;
                    r_hex       <= i_job.hex;
                    r_upper     <= i_job.upper;
                    r_zero_fill <= i_job.zero_fill;
                    r_width     <= i_job.width;
                    r_ndig      <= '0;
                end
            end
            BK_DIV: begin
                r_quot <= r_hex ? {4'd0, r_val[31:4]} : 32'(w_prod[63:RECIP_SH]);
            end
            BK_STORE: begin
                r_digits[DIGIT_IDX_W'(r_ndig)] <= w_digit;
                r_ndig <= r_ndig + NDIG_W'(1);
                r_val  <= r_quot;
            end
            BK_SIGN: begin
                r_pad <= (r_width > WIDTH_W'(r_ndig)) ? (r_width - WIDTH_W'(r_ndig)) : '0;
            end
            BK_PAD: begin
                if (w_emit) begin
                    r_pad <= r_pad - WIDTH_W'(1);
                end
            end
            BK_DIGIT: begin
                if (w_emit) begin
                    r_ndig <= r_ndig - NDIG_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    a_ndig_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_STORE) |-> (r_ndig < NDIG_W'(DIGITS_MAX)))
        else $error("digit store overflow");

    a_digits_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_SIGN || r_state == BK_PAD || r_state == BK_DIGIT) |-> (r_ndig != '0))
        else $error("emit phase entered with no digits");

    a_hex_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_STORE && r_hex) |-> (r_ndig < NDIG_W'(8)))
        else $error("hex value produced more than eight digits");

endmodule

`default_nettype wire

// File: design/integer_to_ascii_formatter.sv
// Top level of the integer-to-ASCII formatter: front end, job queue and back end.
//
// Each number beat (mode, value, min_width, zero_fill) turns into a run of character
// beats, most significant first, with last set on the final digit. In the back end a
// number passes through these steps in order: the job is taken from the queue; each of
// its D digits (at most 10 decimal or 8 hex) takes a divide step, a reciprocal multiply
// for decimal or a shift for hex, and a store step; the sign step emits the minus sign
// of a negative number; the padding step emits the padding and then closes; and the
// digit step emits the digits. The output register moves one character per cycle while
// the output is not stalled. The two-entry job queue lets the front end take up to two
// further numbers while the back end is busy.
`default_nettype none

module integer_to_ascii_formatter import ita_pkg::*; #(
    parameter int MAX_WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ita_in_if.sink    i_item,
    ita_out_if.source o_out
);

    t_job w_front_job;
    logic w_push;
    logic w_q_ready;
    t_job w_q_job;
    logic w_q_valid;
    logic w_pop;

    ita_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_item    (i_item),
        .i_q_ready (w_q_ready),
        .o_job     (w_front_job),
        .o_push    (w_push)
    );

    ita_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_ready (w_q_ready),
        .o_job   (w_q_job),
        .o_valid (w_q_valid),
        .i_pop   (w_pop)
    );

    ita_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_q_job),
        .i_job_valid (w_q_valid),
        .o_job_pop   (w_pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
